[src/mwf_pkg.sv]
// Shared codes and fixed widths for the maze wall follower walker.
package mwf_pkg;

	// Width of every configuration register and of the config data bus.
	localparam int unsigned CFG_W = 6;

	// Item commands.
	typedef enum logic [1:0] {
		CMD_STEP    = 2'd0,
		CMD_READ    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_START_ROW = 2'd0,
		CFG_START_COL = 2'd1,
		CFG_END_ROW   = 2'd2,
		CFG_END_COL   = 2'd3
	} cfg_idx_t;

	// Headings.
	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	// XOR with this flips a heading to its opposite.
	localparam logic [1:0] DIR_FLIP = 2'd2;

	// Heading after turning right / left.
	function automatic logic [1:0] turn_right(input logic [1:0] h);
		turn_right = h + 2'd1;
	endfunction

	function automatic logic [1:0] turn_left(input logic [1:0] h);
		turn_left = h + 2'd3;
	endfunction

endpackage

[src/mwf_path_ram.sv]
// Path stack storage: one write port, one read port with registered read data.
module mwf_path_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data
);

	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/maze_wall_follower_walker_top.sv]
// Right-hand wall follower walker with its path stack kept in a RAM.
// An accepted beat passes stage 1, then the output register, to m_tdata.
// Throughput: one beat per cycle unless m_tready stalls; a pop forwards the
//   refilled stack top from the RAM read data, so back-to-back steps never
//   wait on the RAM. Reset: arst_n puts the walker on the start cell facing
//   north with an empty path and overflow clear; s_tready waits for run_q.
module maze_wall_follower_walker_top #(
	parameter int unsigned GRID_SIDE  = 64,
	parameter int unsigned PATH_DEPTH = 4096,
	localparam int unsigned RW       = $clog2(GRID_SIDE),
	localparam int unsigned IW       = $clog2(PATH_DEPTH),
	localparam int unsigned LW       = $clog2(PATH_DEPTH + 1),
	localparam int unsigned IN_BITS  = 6 + IW,
	localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_BITS = 6 + 2 * RW + LW,
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// config write port
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [mwf_pkg::CFG_W-1:0] cfg_data,
	// input beats
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_W-1:0]          s_tdata,   // cmd, open_mask, read_index
	// result beats
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_W-1:0]         m_tdata    // move_dir, row, col, at_end,
	                                            // path_length, path_entry, overflow
);

	localparam int unsigned CMPW = (RW > mwf_pkg::CFG_W) ? RW : mwf_pkg::CFG_W;
	localparam logic [RW-1:0] MAX_POS = RW'(GRID_SIDE - 1);
	localparam logic [LW-1:0] FULL    = LW'(PATH_DEPTH);

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [mwf_pkg::CFG_W-1:0] start_row_q, start_col_q, end_row_q, end_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= '0;
			start_col_q <= '0;
			end_row_q   <= mwf_pkg::CFG_W'(63);
			end_col_q   <= mwf_pkg::CFG_W'(63);
		end else if (cfg_we) begin
			case (mwf_pkg::cfg_idx_t'(cfg_index))
				mwf_pkg::CFG_START_ROW: start_row_q <= cfg_data;
				mwf_pkg::CFG_START_COL: start_col_q <= cfg_data;
				mwf_pkg::CFG_END_ROW:   end_row_q   <= cfg_data;
				mwf_pkg::CFG_END_COL:   end_col_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Input beat fields
	// ---------------------------------------------------------------------
	mwf_pkg::cmd_t cmd;
	logic [3:0]    open_mask;
	logic [IW-1:0] read_index;

	assign cmd        = mwf_pkg::cmd_t'(s_tdata[1:0]);
	assign open_mask  = s_tdata[5:2];
	assign read_index = s_tdata[6 +: IW];

	// ---------------------------------------------------------------------
	// Walker state
	// ---------------------------------------------------------------------
	logic [RW-1:0] row_q, col_q;
	logic [1:0]    head_q;
	logic [LW-1:0] count_q;
	logic          ovf_q;
	logic [1:0]    top_q;       // copy of the stack top entry

	// stage 1: RAM read in flight, status fields already final
	logic          valid_s1, refill_s1, read_ok_s1;
	logic [1:0]    dir_s1;
	logic [RW-1:0] row_s1, col_s1;
	logic          at_end_s1, ovf_s1;
	logic [LW-1:0] len_s1;

	logic          out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic [1:0]    rd_data;
	logic          acc, s1_adv;
	logic          run_q;       // low in reset; registers the release of arst_n

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign s1_adv   = !out_valid_q || m_tready;
	assign s_tready = run_q && (!valid_s1 || s1_adv);
	assign acc      = s_tvalid && s_tready;

	// ---------------------------------------------------------------------
	// Next-state logic for the beat at the input
	// ---------------------------------------------------------------------
	logic          goal_now, step_mv, do_pop, do_push, full;
	logic [1:0]    rgt, lft, dir, top_eff;
	logic [RW-1:0] row_nxt, col_nxt, st_row, st_col;
	logic [1:0]    head_nxt;
	logic [LW-1:0] count_nxt, cnt_m2;
	logic          ovf_nxt, at_end_nxt, read_ok;
	logic          wr_en, rd_en, refill;
	logic [IW-1:0] rd_addr;

	assign goal_now = (CMPW'(row_q) == CMPW'(end_row_q)) && (CMPW'(col_q) == CMPW'(end_col_q));

	assign rgt = mwf_pkg::turn_right(head_q);
	assign lft = mwf_pkg::turn_left(head_q);

	// right, then straight, then left, else turn back
	always_comb begin
		if (open_mask[rgt]) begin
			dir = rgt;
		end else if (open_mask[head_q]) begin
			dir = head_q;
		end else if (open_mask[lft]) begin
			dir = lft;
		end else begin
			dir = head_q ^ mwf_pkg::DIR_FLIP;
		end
	end

	// forward the refill read when the previous beat popped
	assign top_eff = (valid_s1 && refill_s1) ? rd_data : top_q;

	assign full    = (count_q == FULL);
	assign do_pop  = (count_q != '0) && (top_eff == (dir ^ mwf_pkg::DIR_FLIP));
	assign do_push = !do_pop && !full;
	assign step_mv = (cmd == mwf_pkg::CMD_STEP) && !goal_now;

	// start cell clamped into the grid
	assign st_row = (CMPW'(start_row_q) > CMPW'(MAX_POS)) ? MAX_POS : RW'(start_row_q);
	assign st_col = (CMPW'(start_col_q) > CMPW'(MAX_POS)) ? MAX_POS : RW'(start_col_q);

	assign cnt_m2  = count_q - LW'(2);
	assign read_ok = (LW'(read_index) < count_q);

	always_comb begin
		row_nxt   = row_q;
		col_nxt   = col_q;
		head_nxt  = head_q;
		count_nxt = count_q;
		ovf_nxt   = ovf_q;
		case (cmd)
			mwf_pkg::CMD_STEP: begin
				if (step_mv) begin
					head_nxt = dir;
					if (do_pop) begin
						count_nxt = count_q - LW'(1);
					end else if (do_push) begin
						count_nxt = count_q + LW'(1);
					end else begin
						ovf_nxt = 1'b1;
					end
					// clamp at the grid edges
					case (dir)
						mwf_pkg::DIR_N: row_nxt = (row_q == '0) ? row_q : row_q - RW'(1);
						mwf_pkg::DIR_E: col_nxt = (col_q == MAX_POS) ? col_q : col_q + RW'(1);
						mwf_pkg::DIR_S: row_nxt = (row_q == MAX_POS) ? row_q : row_q + RW'(1);
						default:        col_nxt = (col_q == '0) ? col_q : col_q - RW'(1);
					endcase
				end
			end
			mwf_pkg::CMD_RESTART: begin
				row_nxt   = st_row;
				col_nxt   = st_col;
				head_nxt  = mwf_pkg::DIR_N;
				count_nxt = '0;
				ovf_nxt   = 1'b0;
			end
			default: ;
		endcase
	end

	assign at_end_nxt = (CMPW'(row_nxt) == CMPW'(end_row_q)) &&
	                    (CMPW'(col_nxt) == CMPW'(end_col_q));

	// RAM traffic: push writes the new top; pop reads the entry below it; READ reads read_index
	assign wr_en   = acc && step_mv && do_push;
	assign refill  = step_mv && do_pop && (count_q != LW'(1));
	assign rd_en   = acc && ((cmd == mwf_pkg::CMD_READ) || refill);
	assign rd_addr = (cmd == mwf_pkg::CMD_READ) ? read_index : cnt_m2[IW-1:0];

	mwf_path_ram #(
		.DEPTH (PATH_DEPTH),
		.AW    (IW)
	) u_path_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (dir),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// ---------------------------------------------------------------------
	// State update
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			head_q  <= mwf_pkg::DIR_N;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (acc) begin
			row_q   <= row_nxt;
			col_q   <= col_nxt;
			head_q  <= head_nxt;
			count_q <= count_nxt;
			ovf_q   <= ovf_nxt;
		end
	end

	// Stack top copy: a push sets it, a finished refill read loads it.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			top_q <= dir;
		end else if (valid_s1 && refill_s1) begin
			top_q <= rd_data;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1 and output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			refill_s1  <= refill;
			read_ok_s1 <= (cmd == mwf_pkg::CMD_READ) && read_ok;
			dir_s1     <= head_nxt;
			row_s1     <= row_nxt;
			col_s1     <= col_nxt;
			at_end_s1  <= at_end_nxt;
			len_s1     <= count_nxt;
			ovf_s1     <= ovf_nxt;
		end
		if (s1_adv && valid_s1) begin
			out_data_q <= OUT_W'({ovf_s1, (read_ok_s1 ? rd_data : 2'd0), len_s1,
			                      at_end_s1, col_s1, row_s1, dir_s1});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("path count beyond stack depth");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && !s_tready) |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a held result");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> (count_q == FULL))
		else $error("overflow set with room on the stack");

	a_refill_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && refill_s1) |-> (count_q != '0))
		else $error("stack refill pending on an empty stack");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the maze wall follower walker: directed and random beats.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned GRID_SIDE  = 64;
	localparam int unsigned PATH_DEPTH = 4096;
	localparam logic [5:0]  EDGE_MAX   = 6'(GRID_SIDE - 1);

	// One input beat, highest field first in the packed bus.
	typedef struct packed {
		logic [11:0]   read_index;
		logic [3:0]    open_mask;
		mwf_pkg::cmd_t cmd;
	} walk_beat_t;

	// One result beat, move_dir in the lowest bits.
	typedef struct packed {
		logic        overflow;
		logic [1:0]  path_entry;
		logic [12:0] path_length;
		logic        at_end;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [1:0]  move_dir;
	} walk_status_t;

	// DUT ports; every input known from time zero.
	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [1:0]                cfg_index = '0;
	logic [mwf_pkg::CFG_W-1:0] cfg_data  = '0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [23:0]               s_tdata   = '0;   // cmd, open_mask, read_index
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [31:0]               m_tdata;          // move_dir, row, col, at_end,
	                                             // path_length, path_entry, overflow

	// Beats waiting to go out, and statuses the walker should report.
	walk_beat_t   walk_beats_q[$];
	walk_status_t want_status_q[$];

	int unsigned errors        = 0;
	bit          src_idle_en   = 1'b1;
	bit          sink_stall_en = 1'b1;
	int unsigned src_gap       = 0;
	int unsigned sink_gap      = 0;

	// Shadow of the register file and of the walker itself.
	logic [5:0]  start_row_r    = '0;
	logic [5:0]  start_col_r    = '0;
	logic [5:0]  end_row_r      = EDGE_MAX;
	logic [5:0]  end_col_r      = EDGE_MAX;
	logic [5:0]  walker_row     = '0;
	logic [5:0]  walker_col     = '0;
	logic [1:0]  walker_heading = mwf_pkg::DIR_N;
	logic [1:0]  trail_mem [PATH_DEPTH];
	logic [12:0] trail_len      = '0;
	logic        trail_overflow = 1'b0;

	maze_wall_follower_walker_top #(
		.GRID_SIDE (GRID_SIDE),
		.PATH_DEPTH(PATH_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	function automatic logic on_goal();
		return (walker_row == end_row_r) && (walker_col == end_col_r);
	endfunction

	// Walker model: apply one accepted beat and queue the status it must produce.
	task automatic advance_walker(input walk_beat_t b);
		walk_status_t st;
		logic [1:0]   rgt;
		logic [1:0]   lft;
		logic [1:0]   dir;
		logic [1:0]   entry;
		entry = 2'd0;
		case (b.cmd)
			mwf_pkg::CMD_STEP: begin
				// goal cell swallows steps
				if (!on_goal()) begin
					rgt = walker_heading + 2'd1;
					lft = walker_heading + 2'd3;
					if (b.open_mask[rgt])
						dir = rgt;
					else if (b.open_mask[walker_heading])
						dir = walker_heading;
					else if (b.open_mask[lft])
						dir = lft;
					else
						dir = walker_heading ^ mwf_pkg::DIR_FLIP;   // dead end: back out regardless
					walker_heading = dir;
					// backtracking over the top entry pops it, anything else pushes, or flags overflow when full
					if (trail_len != 0 &&
					    trail_mem[12'(trail_len - 13'd1)] == (dir ^ mwf_pkg::DIR_FLIP)) begin
						trail_len = trail_len - 13'd1;
					end else if (trail_len < PATH_DEPTH) begin
						trail_mem[12'(trail_len)] = dir;
						trail_len = trail_len + 13'd1;
					end else begin
						trail_overflow = 1'b1;
					end
					// position saturates at the grid border
					case (dir)
						mwf_pkg::DIR_N: if (walker_row != 0) walker_row = walker_row - 6'd1;
						mwf_pkg::DIR_E: if (walker_col != EDGE_MAX) walker_col = walker_col + 6'd1;
						mwf_pkg::DIR_S: if (walker_row != EDGE_MAX) walker_row = walker_row + 6'd1;
						default: if (walker_col != 0) walker_col = walker_col - 6'd1;
					endcase
				end
			end
			mwf_pkg::CMD_READ: begin
				if (b.read_index < trail_len)
					entry = trail_mem[b.read_index];
			end
			mwf_pkg::CMD_RESTART: begin
				walker_row     = start_row_r;
				walker_col     = start_col_r;
				walker_heading = mwf_pkg::DIR_N;
				trail_len      = '0;
				trail_overflow = 1'b0;
			end
			default: ;
		endcase
		st.move_dir    = walker_heading;
		st.row         = walker_row;
		st.col         = walker_col;
		st.at_end      = on_goal();
		st.path_length = trail_len;
		st.path_entry  = entry;
		st.overflow    = trail_overflow;
		want_status_q = {want_status_q, st};
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// Source side: one beat per handshake, random idle bursts after a beat.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			advance_walker(walk_beat_t'(s_tdata[17:0]));
		if (s_tvalid && !s_tready) begin
			// beat stalled, hold it
		end else if (src_gap != 0) begin
			src_gap--;
			s_tvalid <= 1'b0;
		end else if (walk_beats_q.size() != 0) begin
			s_tdata  <= {6'd0, walk_beats_q.pop_front()};
			s_tvalid <= 1'b1;
			if (src_idle_en && $urandom_range(0, 7) == 0)
				src_gap = $urandom_range(1, 14);
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Sink side: compare each result beat against the oldest prediction.
	always @(posedge clk) begin : result_check
		walk_status_t got;
		walk_status_t want;
		if (m_tvalid && m_tready) begin
			got = walk_status_t'(m_tdata[30:0]);
			if (want_status_q.size() == 0) begin
				$display("%0t ns: stray result beat, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				want = want_status_q.pop_front();
				check_field("move_dir", want.move_dir, got.move_dir);
				check_field("row", want.row, got.row);
				check_field("col", want.col, got.col);
				check_field("at_end", want.at_end, got.at_end);
				check_field("path_length", want.path_length, got.path_length);
				check_field("path_entry", want.path_entry, got.path_entry);
				check_field("overflow", want.overflow, got.overflow);
			end
		end
		// backpressure in random bursts when stalls are enabled
		if (sink_gap != 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else if (sink_stall_en && $urandom_range(0, 9) == 0) begin
			sink_gap = $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send(input mwf_pkg::cmd_t c, input logic [3:0] m, input logic [11:0] r);
		walk_beat_t b;
		b.cmd        = c;
		b.open_mask  = m;
		b.read_index = r;
		walk_beats_q = {walk_beats_q, b};
	endtask

	// A single open side forces that heading (the back side is taken anyway).
	task automatic step_toward(input logic [1:0] d);
		send(mwf_pkg::CMD_STEP, 4'b0001 << d, 12'd0);
	endtask

	// Drain: nothing queued, nothing on the bus, every result back. Sampled
	// on the falling edge so the clocked blocks have settled.
	task automatic wait_idle();
		@(negedge clk);
		while (walk_beats_q.size() != 0 || s_tvalid || want_status_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input mwf_pkg::cfg_idx_t idx, input logic [5:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mwf_pkg::CFG_START_ROW: start_row_r = val;
			mwf_pkg::CFG_START_COL: start_col_r = val;
			mwf_pkg::CFG_END_ROW:   end_row_r   = val;
			default:                end_col_r   = val;
		endcase
	endtask

	task automatic set_cells(input logic [5:0] sr, input logic [5:0] sc,
	                         input logic [5:0] er, input logic [5:0] ec);
		write_reg(mwf_pkg::CFG_START_ROW, sr);
		write_reg(mwf_pkg::CFG_START_COL, sc);
		write_reg(mwf_pkg::CFG_END_ROW, er);
		write_reg(mwf_pkg::CFG_END_COL, ec);
	endtask

	// Mostly steps with random walls, some reads, restarts and unused codes.
	task automatic random_block(input int unsigned n);
		int unsigned pick;
		logic [11:0] idx;
		for (int unsigned i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			idx  = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095)) :
			                                     12'($urandom_range(0, 15));
			if (pick < 74)
				send(mwf_pkg::CMD_STEP, 4'($urandom_range(0, 15)),
				     12'($urandom_range(0, 4095)));
			else if (pick < 88)
				send(mwf_pkg::CMD_READ, 4'($urandom_range(0, 15)), idx);
			else if (pick < 96)
				send(mwf_pkg::CMD_RESTART, 4'($urandom_range(0, 15)),
				     12'($urandom_range(0, 4095)));
			else
				send(mwf_pkg::CMD_NOP, 4'($urandom_range(0, 15)),
				     12'($urandom_range(0, 4095)));
		end
	endtask

	task automatic shuffle_idling();
		src_idle_en   = ($urandom_range(0, 3) != 0);
		sink_stall_en = ($urandom_range(0, 3) != 0);
	endtask

	initial begin : stimulus
		logic [1:0] last_d;
		logic [5:0] r;
		logic [5:0] c;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: walker starts at (0,0) facing north, goal at (63,63).
		send(mwf_pkg::CMD_STEP, 4'b0000, 12'd0);     // dead end, back out south
		send(mwf_pkg::CMD_STEP, 4'b1111, 12'd4095);  // all open: right turn, west, clamped
		step_toward(mwf_pkg::DIR_E);                 // only back side open: undoes west, pop
		step_toward(mwf_pkg::DIR_N);                 // undoes south, path empty again
		step_toward(mwf_pkg::DIR_N);                 // push, clamped at row 0
		send(mwf_pkg::CMD_READ, 4'b0000, 12'd0);
		send(mwf_pkg::CMD_READ, 4'b1111, 12'd1);     // past the top of the path
		send(mwf_pkg::CMD_NOP, 4'b1111, 12'd4095);
		send(mwf_pkg::CMD_RESTART, 4'b1010, 12'd2730);

		// Short run of pushes: north/west never undo each other, so every
		// step pushes while the walker sits clamped in the corner.
		last_d = mwf_pkg::DIR_N;
		for (int unsigned k = 0; k < 20; k++) begin
			last_d = $urandom_range(0, 1) ? mwf_pkg::DIR_N : mwf_pkg::DIR_W;
			step_toward(last_d);
		end
		send(mwf_pkg::CMD_READ, 4'b0000, 12'd0);
		send(mwf_pkg::CMD_READ, 4'b0000, 12'd19);
		send(mwf_pkg::CMD_READ, 4'b0000, 12'd20);    // one past the top
		step_toward(last_d ^ mwf_pkg::DIR_FLIP);     // pop
		step_toward(last_d ^ mwf_pkg::DIR_FLIP);     // pops again only if the refilled top matches
		send(mwf_pkg::CMD_READ, 4'b1111, 12'd18);    // out of range if both steps popped
		send(mwf_pkg::CMD_RESTART, 4'b0000, 12'd0);
		send(mwf_pkg::CMD_READ, 4'b0000, 12'd0);
		wait_idle();

		// Far corners swapped. Writes alone must not move the walker, but
		// the goal compare follows the new end cell at once.
		set_cells(EDGE_MAX, EDGE_MAX, 6'd0, 6'd0);
		send(mwf_pkg::CMD_NOP, 4'b0000, 12'd0);
		send(mwf_pkg::CMD_RESTART, 4'b0000, 12'd0);
		send(mwf_pkg::CMD_STEP, 4'b1111, 12'd0);     // east, clamped at col 63
		step_toward(mwf_pkg::DIR_S);                 // south, clamped at row 63
		shuffle_idling();
		random_block(75);
		wait_idle();

		// Start on the goal: steps do nothing until the goal moves away.
		set_cells(6'd0, 6'd0, 6'd0, 6'd0);
		send(mwf_pkg::CMD_RESTART, 4'b0000, 12'd0);
		send(mwf_pkg::CMD_STEP, 4'b1111, 12'd0);
		send(mwf_pkg::CMD_STEP, 4'b0000, 12'd0);
		send(mwf_pkg::CMD_READ, 4'b0000, 12'd0);
		wait_idle();
		write_reg(mwf_pkg::CFG_END_COL, 6'd5);
		send(mwf_pkg::CMD_NOP, 4'b0000, 12'd0);
		shuffle_idling();
		random_block(60);
		wait_idle();

		// Goal close to start, reached often.
		set_cells(6'd20, 6'd20, 6'd21, 6'd22);
		send(mwf_pkg::CMD_NOP, 4'b0000, 12'd0);
		send(mwf_pkg::CMD_RESTART, 4'b0000, 12'd0);
		shuffle_idling();
		random_block(75);

		// Random start, goal a few cells away.
		for (int unsigned p = 0; p < 2; p++) begin
			wait_idle();
			r = 6'($urandom_range(0, 63));
			c = 6'($urandom_range(0, 63));
			set_cells(r, c, r + 6'($urandom_range(0, 3)), c + 6'($urandom_range(0, 3)));
			send(mwf_pkg::CMD_NOP, 4'b0000, 12'd0);
			send(mwf_pkg::CMD_RESTART, 4'b0000, 12'd0);
			shuffle_idling();
			random_block(75);
		end
		wait_idle();

		// Last stretch at full rate on both sides.
		set_cells(6'd0, EDGE_MAX, EDGE_MAX, 6'd0);
		send(mwf_pkg::CMD_RESTART, 4'b0000, 12'd0);
		src_idle_en   = 1'b0;
		sink_stall_en = 1'b0;
		random_block(90);
		wait_idle();
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin : watchdog
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
